/* rtl/core/pls_pkg.sv */
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and codes of the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

  // field widths of the command and result words
  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT_W    = 5;

  // command codes
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_AT   = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP     = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ELEM  = 3'd4;

  // one result word from the sequencer
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] element;
    logic [CNT_W-1:0]        element_count;
    logic                    last;
  } res_t;

endpackage

/* rtl/core/positional_list_store_top.sv */
// ----------------------------------------------------------------------------
// positional_list_store_top
// Ordered list of signed words in RAM with insert, delete and dump commands.
// ----------------------------------------------------------------------------
// An insert or delete moves each shifted entry with one RAM read and one write;
//   a refused command goes straight to its status word.
// A dump reads the RAM once per element; each word waits for the output register to take it.
// One command is in work at a time; the output register takes a new word in
//   the cycle the previous one leaves on the master side.
// Synchronous reset empties the list; RAM contents are not cleared.
module positional_list_store_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // opcode[2:0], position[8:3], value[40:9], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // status[2:0], element[34:3], element_count[39:35]
  output logic        m_axis_tlast
);
  import pls_pkg::*;

  logic  res_valid;
  logic  res_ready;
  res_t  res;
  res_t  out_word;

  pls_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_axis_tvalid),
    .cmd_ready (s_axis_tready),
    .opcode    (s_axis_tdata[2:0]),
    .position  (s_axis_tdata[8:3]),
    .value     (s_axis_tdata[40:9]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word <= res;
    end
  end

  assign m_axis_tdata = {out_word.element_count, out_word.element, out_word.status};
  assign m_axis_tlast = out_word.last;

endmodule

/* rtl/core/pls_ram.sv */
// ----------------------------------------------------------------------------
// pls_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/pls_seq.sv */
// ----------------------------------------------------------------------------
// pls_seq
// Command sequencer: checks a command, shifts the list in RAM one entry per
// read/write pair, writes the new value and walks the list for a dump.
// ----------------------------------------------------------------------------
module pls_seq #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [pls_pkg::OP_W-1:0]      opcode,
  input  logic [pls_pkg::POS_W-1:0]     position,
  input  logic signed [pls_pkg::VAL_W-1:0] value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output pls_pkg::res_t                 res
);
  import pls_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SH_RD   = 7'b0000010,
    S_SH_WR   = 7'b0000100,
    S_PUT     = 7'b0001000,
    S_RES     = 7'b0010000,
    S_DUMP_RD = 7'b0100000,
    S_DUMP_OUT = 7'b1000000
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       pos;
  logic [VAL_W-1:0]    val;
  logic                ins;
  logic [STATUS_W-1:0] status;

  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  logic [VAL_W-1:0]    ram_wr_data;
  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  logic [VAL_W-1:0]    ram_rd_data;

  logic [CMPW-1:0]     count_ext;
  logic [CMPW-1:0]     pos_sel;
  logic [CMPW-1:0]     idx_ext;
  logic                full;
  logic                empty;
  logic                dump_last;
  logic [CW+CNT_W-1:0] count_wide;

  // list storage
  pls_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // command decode helpers
  always_comb begin
    count_ext = CMPW'(count);
    idx_ext   = CMPW'(idx);
    full      = (count == CW'(DEPTH));
    empty     = (count == '0);
    dump_last = ((idx_ext + CMPW'(1)) == count_ext);
    unique case (opcode)
      OP_INS_TAIL: pos_sel = count_ext;
      OP_INS_AT,
      OP_DEL_AT:   pos_sel = CMPW'(position);
      default:     pos_sel = '0;
    endcase
  end

  // ram port control
  always_comb begin
    ram_rd_en   = (state == S_SH_RD) || (state == S_DUMP_RD);
    ram_rd_addr = idx;
    if (state == S_SH_RD) begin
      ram_rd_addr = ins ? (idx - AW'(1)) : (idx + AW'(1));
    end
    ram_wr_en   = (state == S_SH_WR) || (state == S_PUT);
    ram_wr_addr = (state == S_PUT) ? pos : idx;
    ram_wr_data = (state == S_PUT) ? val : ram_rd_data;
  end

  // result word
  always_comb begin
    count_wide        = {{CNT_W{1'b0}}, count};
    cmd_ready         = (state == S_IDLE);
    res_valid         = (state == S_RES) || (state == S_DUMP_OUT);
    res.element_count = count_wide[CNT_W-1:0];
    if (state == S_DUMP_OUT) begin
      res.status  = ST_ELEM;
      res.element = ram_rd_data;
      res.last    = dump_last;
    end else begin
      res.status  = status;
      res.element = '0;
      res.last    = 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            val <= value;
            unique case (opcode)
              OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
                ins <= 1'b1;
                pos <= pos_sel[AW-1:0];
                idx <= count[AW-1:0];
                if (full) begin
                  status <= ST_FULL;
                  state  <= S_RES;
                end else if (pos_sel > count_ext) begin
                  status <= ST_RANGE;
                  state  <= S_RES;
                end else begin
                  status <= ST_OK;
                  state  <= (pos_sel == count_ext) ? S_PUT : S_SH_RD;
                end
              end
              OP_DEL_AT, OP_DEL_HEAD: begin
                ins <= 1'b0;
                idx <= pos_sel[AW-1:0];
                if (empty) begin
                  status <= ST_EMPTY;
                  state  <= S_RES;
                end else if (pos_sel >= count_ext) begin
                  status <= ST_RANGE;
                  state  <= S_RES;
                end else begin
                  status <= ST_OK;
                  if ((pos_sel + CMPW'(1)) == count_ext) begin
                    count <= count - CW'(1);
                    state <= S_RES;
                  end else begin
                    state <= S_SH_RD;
                  end
                end
              end
              OP_DUMP: begin
                idx <= '0;
                if (empty) begin
                  status <= ST_EMPTY;
                  state  <= S_RES;
                end else begin
                  state <= S_DUMP_RD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          // entry moved; step toward the edit point (insert) or the list end (delete)
          if (ins) begin
            if ((idx - AW'(1)) == pos) begin
              state <= S_PUT;
            end else begin
              idx   <= idx - AW'(1);
              state <= S_SH_RD;
            end
          end else begin
            if ((idx_ext + CMPW'(2)) == count_ext) begin
              count <= count - CW'(1);
              state <= S_RES;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_SH_RD;
            end
          end
        end
        S_PUT: begin
          count <= count + CW'(1);
          state <= S_RES;
        end
        S_RES: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        S_DUMP_RD: state <= S_DUMP_OUT;
        S_DUMP_OUT: begin
          if (res_ready) begin
            if (dump_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_DUMP_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
